FILE: hw/rtl/mfsr_pkg.sv
// Shared types, codes and constants for the monochrome framebuffer shape rasterizer.
// Depends on nothing; the other files of the block except mfsr_ram refer to it by scoped names.

package mfsr_pkg;

   // Default screen size in pixels.
   localparam int DEF_SCREEN_WIDTH  = 128;
   localparam int DEF_SCREEN_HEIGHT = 64;

   // Depth of the draw job queue between front and back.
   localparam int JOB_DEPTH = 4;

   // Bit mask of the leftmost pixel of a byte (pixels are packed MSB first).
   localparam logic [7:0] PIXEL_MSB = 8'h80;

   // Command codes.
   localparam logic [3:0] CMD_PIXEL     = 4'd0;
   localparam logic [3:0] CMD_LINE      = 4'd1;
   localparam logic [3:0] CMD_RECT      = 4'd2;
   localparam logic [3:0] CMD_RECT_FILL = 4'd3;
   localparam logic [3:0] CMD_CIRC      = 4'd4;
   localparam logic [3:0] CMD_CIRC_FILL = 4'd5;
   localparam logic [3:0] CMD_TRI       = 4'd6;
   localparam logic [3:0] CMD_TRI_FILL  = 4'd7;
   localparam logic [3:0] CMD_READ      = 4'd8;

   // Kinds of job that the back end carries out.
   typedef enum logic [1:0] {
      JOB_LINE,
      JOB_READ,
      JOB_END
   } job_kind_type;

   // One job: a line segment, a byte read, or the end of a drawing command.
   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   x0;
      logic [7:0]   y0;
      logic [7:0]   x1;
      logic [7:0]   y1;
      logic [9:0]   addr;
   } job_type;

   // Front end sequencer states.
   typedef enum logic [2:0] {
      F_IDLE,
      F_LIST,
      F_RFILL,
      F_CSTEP,
      F_CEMIT,
      F_TFILL,
      F_END
   } front_state_type;

   // Back end states.
   typedef enum logic [2:0] {
      B_CLEAR,
      B_IDLE,
      B_PIX,
      B_WRITE,
      B_READW
   } back_state_type;

endpackage

FILE: hw/rtl/mfsr_ram.sv
// Generic single-port RAM with registered read data.
// Depends on nothing.

module mfsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write at the address, and read the old contents into the output register.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/mfsr_fifo.sv
// Short job queue between the command front end and the drawing back end.
// Depends on mfsr_pkg for the job word type and the queue depth.

module mfsr_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mfsr_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output mfsr_pkg::job_type pop_data,
   output logic             empty
);

   localparam int PW = $clog2(mfsr_pkg::JOB_DEPTH);

   mfsr_pkg::job_type    slot_ff [mfsr_pkg::JOB_DEPTH];
   logic [PW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [PW:0]          count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == (PW+1)'(mfsr_pkg::JOB_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // Pointer and count updates.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // The front end never pushes into a full queue.
   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("job pushed into a full queue");

   // The count never exceeds the depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PW+1)'(mfsr_pkg::JOB_DEPTH))
      else $error("job queue count out of range");

   // A pop without a push lowers the count by one.
   assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("job queue count did not drop on pop");

endmodule

FILE: hw/rtl/mfsr_front.sv
// Command front end: accepts a command and breaks it into line, end or read jobs.
// Depends on mfsr_pkg for command codes, job word and state types.

module mfsr_front #(
   parameter int SCREEN_WIDTH  = mfsr_pkg::DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = mfsr_pkg::DEF_SCREEN_HEIGHT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [3:0]        cmd,
   input  logic [7:0]        ax,
   input  logic [7:0]        ay,
   input  logic [7:0]        bx,
   input  logic [7:0]        by,
   input  logic [7:0]        cx,
   input  logic [7:0]        cy,
   input  logic [7:0]        extent_w,
   input  logic [7:0]        extent_h,
   input  logic [7:0]        radius,
   input  logic [9:0]        read_addr,
   output logic              busy,
   output logic              job_push,
   output mfsr_pkg::job_type job,
   input  logic              job_full
);

   localparam logic [8:0] W9 = 9'(SCREEN_WIDTH);
   localparam logic [8:0] H9 = 9'(SCREEN_HEIGHT);

   mfsr_pkg::front_state_type state_ff, state_in;

   logic [3:0]        cmd_ff, cmd_in;
   logic [7:0]        ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;
   logic [9:0]        addr_ff;
   logic [7:0]        xw_ff, xw_in, yh_ff, yh_in;
   logic [8:0]        rows_ff, rows_in;
   logic [8:0]        cnt_ff, cnt_in;
   logic [2:0]        idx_ff, idx_in;
   logic signed [11:0] cf_ff, cf_in, cddx_ff, cddx_in, cddy_ff, cddy_in;
   logic [7:0]        cxo_ff, cxo_in, cyo_ff, cyo_in;
   logic [7:0]        tx_ff, tx_in, ty_ff, ty_in;
   logic [8:0]        num_ff, num_in;

   // Accept-time values.
   logic [8:0] sumx, sumy;
   logic       rect_ok;
   logic [7:0] in_ddx, in_ddy, in_den;

   // Circle points around the centre.
   logic [7:0] xp, xm, yp, ym, xpy, xmy, ypx, ymx;

   // Triangle walk values.
   logic [7:0] t_ddx, t_ddy, t_den, t_add;
   logic       t_xmaj, t_xup, t_yup;
   logic [8:0] t_sum;
   logic       t_ovf;

   // Circle step values.
   logic signed [11:0] c_ddy1, c_f1, c_ddx1;
   logic               c_fpos;

   // Output segment.
   logic [7:0] sx0, sy0, sx1, sy1;
   logic       list_last, emit_last;

   // Rectangle clip and triangle set-up from the incoming word.
   always_comb begin
      sumx    = {1'b0, ax} + {1'b0, extent_w};
      sumy    = {1'b0, ay} + {1'b0, extent_h};
      rect_ok = ({1'b0, ax} < W9) && ({1'b0, ay} < H9);
      in_ddx  = (cx >= bx) ? cx - bx : bx - cx;
      in_ddy  = (cy >= by) ? cy - by : by - cy;
      in_den  = (in_ddx >= in_ddy) ? in_ddx : in_ddy;
   end

   // Circle coordinates wrap modulo 256.
   always_comb begin
      xp  = ax_ff + cxo_ff;
      xm  = ax_ff - cxo_ff;
      yp  = ay_ff + cyo_ff;
      ym  = ay_ff - cyo_ff;
      xpy = ax_ff + cyo_ff;
      xmy = ax_ff - cyo_ff;
      ypx = ay_ff + cxo_ff;
      ymx = ay_ff - cxo_ff;
   end

   // Midpoint circle step.
   always_comb begin
      c_fpos = !cf_ff[11];
      c_ddy1 = c_fpos ? cddy_ff + 12'sd2 : cddy_ff;
      c_f1   = c_fpos ? cf_ff + c_ddy1 : cf_ff;
      c_ddx1 = cddx_ff + 12'sd2;
   end

   // Triangle fill walk from b toward c.
   always_comb begin
      t_ddx  = (cx_ff >= bx_ff) ? cx_ff - bx_ff : bx_ff - cx_ff;
      t_ddy  = (cy_ff >= by_ff) ? cy_ff - by_ff : by_ff - cy_ff;
      t_xmaj = (t_ddx >= t_ddy);
      t_den  = t_xmaj ? t_ddx : t_ddy;
      t_add  = t_xmaj ? t_ddy : t_ddx;
      t_xup  = (cx_ff >= bx_ff);
      t_yup  = (cy_ff >= by_ff);
      t_sum  = num_ff + {1'b0, t_add};
      t_ovf  = (t_sum >= {1'b0, t_den});
   end

   // Last entry of the fixed segment list and of one circle octant group.
   always_comb begin
      unique case (cmd_ff)
         mfsr_pkg::CMD_RECT, mfsr_pkg::CMD_CIRC: list_last = (idx_ff == 3'd3);
         mfsr_pkg::CMD_CIRC_FILL:                list_last = (idx_ff == 3'd4);
         mfsr_pkg::CMD_TRI:                      list_last = (idx_ff == 3'd2);
         default:                                list_last = 1'b1;
      endcase
      emit_last = (cmd_ff == mfsr_pkg::CMD_CIRC_FILL) ? (idx_ff == 3'd3) : (idx_ff == 3'd7);
   end

   // Output block: the segment or job word for the current state.
   always_comb begin
      sx0 = ax_ff;
      sy0 = ay_ff;
      sx1 = ax_ff;
      sy1 = ay_ff;
      job_push = 1'b0;
      unique case (state_ff)
         mfsr_pkg::F_LIST: begin
            job_push = 1'b1;
            unique case (cmd_ff)
               mfsr_pkg::CMD_LINE: begin
                  sx1 = bx_ff;
                  sy1 = by_ff;
               end
               mfsr_pkg::CMD_RECT: begin
                  unique case (idx_ff)
                     3'd0: begin sx1 = xw_ff; end
                     3'd1: begin sy0 = yh_ff; sx1 = xw_ff; sy1 = yh_ff; end
                     3'd2: begin sy1 = yh_ff; end
                     default: begin sx0 = xw_ff; sx1 = xw_ff; sy1 = yh_ff; end
                  endcase
               end
               mfsr_pkg::CMD_CIRC, mfsr_pkg::CMD_CIRC_FILL: begin
                  unique case (idx_ff)
                     3'd0: begin sy0 = yp; sy1 = yp; end
                     3'd1: begin sy0 = ym; sy1 = ym; end
                     3'd2: begin sx0 = xpy; sx1 = xpy; end
                     3'd3: begin sx0 = xmy; sx1 = xmy; end
                     default: begin sx0 = xmy; sx1 = xpy; end
                  endcase
               end
               mfsr_pkg::CMD_TRI: begin
                  unique case (idx_ff)
                     3'd0: begin sx0 = bx_ff; sy0 = by_ff; sx1 = cx_ff; sy1 = cy_ff; end
                     3'd1: begin sx0 = cx_ff; sy0 = cy_ff; end
                     default: begin sx1 = bx_ff; sy1 = by_ff; end
                  endcase
               end
               default: begin
               end
            endcase
         end
         mfsr_pkg::F_RFILL: begin
            job_push = 1'b1;
            sy0 = ay_ff + cnt_ff[7:0];
            sx1 = xw_ff;
            sy1 = sy0;
         end
         mfsr_pkg::F_CEMIT: begin
            job_push = 1'b1;
            if (cmd_ff == mfsr_pkg::CMD_CIRC_FILL) begin
               unique case (idx_ff[1:0])
                  2'd0: begin sx0 = xm;  sy0 = yp;  sx1 = xp;  sy1 = yp;  end
                  2'd1: begin sx0 = xp;  sy0 = ym;  sx1 = xm;  sy1 = ym;  end
                  2'd2: begin sx0 = xpy; sy0 = ypx; sx1 = xmy; sy1 = ypx; end
                  default: begin sx0 = xpy; sy0 = ymx; sx1 = xmy; sy1 = ymx; end
               endcase
            end else begin
               unique case (idx_ff)
                  3'd0: begin sx0 = xp;  sy0 = yp;  end
                  3'd1: begin sx0 = xm;  sy0 = yp;  end
                  3'd2: begin sx0 = xp;  sy0 = ym;  end
                  3'd3: begin sx0 = xm;  sy0 = ym;  end
                  3'd4: begin sx0 = xpy; sy0 = ypx; end
                  3'd5: begin sx0 = xmy; sy0 = ypx; end
                  3'd6: begin sx0 = xpy; sy0 = ymx; end
                  default: begin sx0 = xmy; sy0 = ymx; end
               endcase
               sx1 = sx0;
               sy1 = sy0;
            end
         end
         mfsr_pkg::F_TFILL: begin
            job_push = 1'b1;
            sx0 = tx_ff;
            sy0 = ty_ff;
         end
         mfsr_pkg::F_END: begin
            job_push = 1'b1;
         end
         default: begin
         end
      endcase
      job.x0   = sx0;
      job.y0   = sy0;
      job.x1   = sx1;
      job.y1   = sy1;
      job.addr = addr_ff;
      if (state_ff == mfsr_pkg::F_END) begin
         job.kind = (cmd_ff == mfsr_pkg::CMD_READ) ? mfsr_pkg::JOB_READ : mfsr_pkg::JOB_END;
      end else begin
         job.kind = mfsr_pkg::JOB_LINE;
      end
   end

   assign busy = (state_ff != mfsr_pkg::F_IDLE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mfsr_pkg::F_IDLE: begin
            if (accept) begin
               unique case (cmd)
                  mfsr_pkg::CMD_PIXEL, mfsr_pkg::CMD_LINE, mfsr_pkg::CMD_CIRC,
                  mfsr_pkg::CMD_CIRC_FILL, mfsr_pkg::CMD_TRI:
                     state_in = mfsr_pkg::F_LIST;
                  mfsr_pkg::CMD_RECT:
                     state_in = rect_ok ? mfsr_pkg::F_LIST : mfsr_pkg::F_END;
                  mfsr_pkg::CMD_RECT_FILL:
                     state_in = rect_ok ? mfsr_pkg::F_RFILL : mfsr_pkg::F_END;
                  mfsr_pkg::CMD_TRI_FILL:
                     state_in = mfsr_pkg::F_TFILL;
                  default:
                     state_in = mfsr_pkg::F_END;
               endcase
            end
         end
         mfsr_pkg::F_LIST: begin
            if (!job_full && list_last) begin
               if (cmd_ff == mfsr_pkg::CMD_CIRC || cmd_ff == mfsr_pkg::CMD_CIRC_FILL) begin
                  state_in = mfsr_pkg::F_CSTEP;
               end else begin
                  state_in = mfsr_pkg::F_END;
               end
            end
         end
         mfsr_pkg::F_RFILL: begin
            if (!job_full && cnt_ff == rows_ff) begin
               state_in = mfsr_pkg::F_END;
            end
         end
         mfsr_pkg::F_CSTEP: begin
            state_in = (cxo_ff < cyo_ff) ? mfsr_pkg::F_CEMIT : mfsr_pkg::F_END;
         end
         mfsr_pkg::F_CEMIT: begin
            if (!job_full && emit_last) begin
               state_in = mfsr_pkg::F_CSTEP;
            end
         end
         mfsr_pkg::F_TFILL: begin
            if (!job_full && cnt_ff == {1'b0, t_den}) begin
               state_in = mfsr_pkg::F_END;
            end
         end
         mfsr_pkg::F_END: begin
            if (!job_full) begin
               state_in = mfsr_pkg::F_IDLE;
            end
         end
         default: state_in = mfsr_pkg::F_IDLE;
      endcase
   end

   // Working register updates.
   always_comb begin
      cmd_in  = cmd_ff;
      xw_in   = xw_ff;
      yh_in   = yh_ff;
      rows_in = rows_ff;
      cnt_in  = cnt_ff;
      idx_in  = idx_ff;
      cf_in   = cf_ff;
      cddx_in = cddx_ff;
      cddy_in = cddy_ff;
      cxo_in  = cxo_ff;
      cyo_in  = cyo_ff;
      tx_in   = tx_ff;
      ty_in   = ty_ff;
      num_in  = num_ff;
      unique case (state_ff)
         mfsr_pkg::F_IDLE: begin
            cmd_in  = cmd;
            xw_in   = (sumx >= W9) ? W9[7:0] : sumx[7:0];
            yh_in   = (sumy >= H9) ? H9[7:0] : sumy[7:0];
            rows_in = (sumy >= H9) ? H9 - {1'b0, ay} : {1'b0, extent_h};
            cnt_in  = '0;
            idx_in  = '0;
            cf_in   = 12'sd1 - $signed({4'b0, radius});
            cddx_in = 12'sd1;
            cddy_in = -$signed({3'b0, radius, 1'b0});
            cxo_in  = '0;
            cyo_in  = radius;
            tx_in   = bx;
            ty_in   = by;
            num_in  = {2'b0, in_den[7:1]};
         end
         mfsr_pkg::F_LIST, mfsr_pkg::F_CEMIT: begin
            if (!job_full) begin
               idx_in = (state_ff == mfsr_pkg::F_LIST ? list_last : emit_last) ?
                        3'd0 : idx_ff + 3'd1;
            end
         end
         mfsr_pkg::F_RFILL: begin
            if (!job_full) begin
               cnt_in = cnt_ff + 9'd1;
            end
         end
         mfsr_pkg::F_CSTEP: begin
            if (cxo_ff < cyo_ff) begin
               cddy_in = c_ddy1;
               cyo_in  = c_fpos ? cyo_ff - 8'd1 : cyo_ff;
               cxo_in  = cxo_ff + 8'd1;
               cddx_in = c_ddx1;
               cf_in   = c_f1 + c_ddx1;
            end
         end
         mfsr_pkg::F_TFILL: begin
            if (!job_full) begin
               cnt_in = cnt_ff + 9'd1;
               num_in = t_ovf ? t_sum - {1'b0, t_den} : t_sum;
               if (t_xmaj || t_ovf) begin
                  tx_in = t_xup ? tx_ff + 8'd1 : tx_ff - 8'd1;
               end
               if (!t_xmaj || t_ovf) begin
                  ty_in = t_yup ? ty_ff + 8'd1 : ty_ff - 8'd1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mfsr_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Captured command fields and walk registers.
   always_ff @(posedge clock) begin
      if (state_ff == mfsr_pkg::F_IDLE) begin
         ax_ff   <= ax;
         ay_ff   <= ay;
         bx_ff   <= bx;
         by_ff   <= by;
         cx_ff   <= cx;
         cy_ff   <= cy;
         addr_ff <= read_addr;
      end
      cmd_ff  <= cmd_in;
      xw_ff   <= xw_in;
      yh_ff   <= yh_in;
      rows_ff <= rows_in;
      cnt_ff  <= cnt_in;
      idx_ff  <= idx_in;
      cf_ff   <= cf_in;
      cddx_ff <= cddx_in;
      cddy_ff <= cddy_in;
      cxo_ff  <= cxo_in;
      cyo_ff  <= cyo_in;
      tx_ff   <= tx_in;
      ty_ff   <= ty_in;
      num_ff  <= num_in;
   end

endmodule

FILE: hw/rtl/mfsr_back.sv
// Drawing back end: clears the framebuffer, walks Bresenham lines with
// read-modify-write per pixel, serves byte reads and holds the result word.
// Depends on mfsr_pkg and mfsr_ram.

module mfsr_back #(
   parameter int SCREEN_WIDTH  = mfsr_pkg::DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = mfsr_pkg::DEF_SCREEN_HEIGHT
) (
   input  logic              clock,
   input  logic              reset,
   input  mfsr_pkg::job_type job,
   input  logic              job_empty,
   output logic              job_pop,
   output logic              clearing,
   output logic              rsp_valid,
   output logic [7:0]        rsp_data,
   input  logic              rsp_take
);

   localparam int ROW_BYTES   = (SCREEN_WIDTH + 7) / 8;
   localparam int FRAME_BYTES = ROW_BYTES * SCREEN_HEIGHT;
   localparam int AW          = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
   localparam logic [8:0] W9  = 9'(SCREEN_WIDTH);
   localparam logic [8:0] H9  = 9'(SCREEN_HEIGHT);

   mfsr_pkg::back_state_type state_ff, state_in;

   logic [7:0]         px_ff, px_in, py_ff, py_in, ex_ff, ex_in, ey_ff, ey_in;
   logic [7:0]         dx_ff, dx_in, dy_ff, dy_in;
   logic               sx_ff, sx_in, sy_ff, sy_in;
   logic signed [11:0] err_ff, err_in;
   logic [AW-1:0]      widx_ff, widx_in, clr_ff, clr_in;
   logic [7:0]         mask_ff, mask_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_data_ff, rsp_data_in;

   logic               ram_we;
   logic [AW-1:0]      ram_addr;
   logic [7:0]         ram_wdata, ram_rdata;

   logic               on_screen, line_done, step_x, step_y, read_ok;
   logic signed [12:0] e2;
   logic [13:0]        pix_idx, rd_idx;
   logic [7:0]         ldx, ldy;

   mfsr_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   // Pixel address, clip test and Bresenham step decisions.
   always_comb begin
      on_screen = ({1'b0, px_ff} < W9) && ({1'b0, py_ff} < H9);
      pix_idx   = {6'b0, py_ff} * 14'(ROW_BYTES) + {9'b0, px_ff[7:3]};
      rd_idx    = {4'b0, job.addr};
      read_ok   = (rd_idx < 14'(FRAME_BYTES));
      line_done = (px_ff == ex_ff) && (py_ff == ey_ff);
      e2        = {err_ff, 1'b0};
      step_x    = e2 > -$signed({5'b0, dy_ff});
      step_y    = e2 < $signed({5'b0, dx_ff});
      ldx       = (job.x1 >= job.x0) ? job.x1 - job.x0 : job.x0 - job.x1;
      ldy       = (job.y1 >= job.y0) ? job.y1 - job.y0 : job.y0 - job.y1;
   end

   assign clearing  = (state_ff == mfsr_pkg::B_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Output block: memory port and queue pop.
   always_comb begin
      ram_we    = 1'b0;
      ram_addr  = widx_ff;
      ram_wdata = ram_rdata | mask_ff;
      job_pop   = 1'b0;
      unique case (state_ff)
         mfsr_pkg::B_CLEAR: begin
            ram_we    = 1'b1;
            ram_addr  = clr_ff;
            ram_wdata = '0;
         end
         mfsr_pkg::B_IDLE: begin
            ram_addr = rd_idx[AW-1:0];
            if (!job_empty && (job.kind == mfsr_pkg::JOB_LINE || !rsp_valid_ff)) begin
               job_pop = 1'b1;
            end
         end
         mfsr_pkg::B_PIX: begin
            ram_addr = pix_idx[AW-1:0];
         end
         mfsr_pkg::B_WRITE: begin
            ram_we = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mfsr_pkg::B_CLEAR: begin
            if (clr_ff == AW'(FRAME_BYTES - 1)) begin
               state_in = mfsr_pkg::B_IDLE;
            end
         end
         mfsr_pkg::B_IDLE: begin
            if (job_pop) begin
               unique case (job.kind)
                  mfsr_pkg::JOB_LINE: state_in = mfsr_pkg::B_PIX;
                  mfsr_pkg::JOB_READ: state_in = read_ok ? mfsr_pkg::B_READW : mfsr_pkg::B_IDLE;
                  default:            state_in = mfsr_pkg::B_IDLE;
               endcase
            end
         end
         mfsr_pkg::B_PIX: begin
            if (on_screen) begin
               state_in = mfsr_pkg::B_WRITE;
            end else if (line_done) begin
               state_in = mfsr_pkg::B_IDLE;
            end
         end
         mfsr_pkg::B_WRITE: begin
            state_in = line_done ? mfsr_pkg::B_IDLE : mfsr_pkg::B_PIX;
         end
         mfsr_pkg::B_READW: state_in = mfsr_pkg::B_IDLE;
         default:           state_in = mfsr_pkg::B_IDLE;
      endcase
   end

   // Line walk, clear counter and result register.
   always_comb begin
      px_in        = px_ff;
      py_in        = py_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      err_in       = err_ff;
      widx_in      = widx_ff;
      mask_in      = mask_ff;
      clr_in       = clr_ff + 1'b1;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         mfsr_pkg::B_IDLE: begin
            if (job_pop) begin
               unique case (job.kind)
                  mfsr_pkg::JOB_LINE: begin
                     px_in  = job.x0;
                     py_in  = job.y0;
                     ex_in  = job.x1;
                     ey_in  = job.y1;
                     dx_in  = ldx;
                     dy_in  = ldy;
                     sx_in  = (job.x0 < job.x1);
                     sy_in  = (job.y0 < job.y1);
                     err_in = $signed({4'b0, ldx}) - $signed({4'b0, ldy});
                  end
                  mfsr_pkg::JOB_READ: begin
                     if (!read_ok) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '0;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                  end
               endcase
            end
         end
         mfsr_pkg::B_PIX, mfsr_pkg::B_WRITE: begin
            if (state_ff == mfsr_pkg::B_PIX && on_screen) begin
               widx_in = pix_idx[AW-1:0];
               mask_in = mfsr_pkg::PIXEL_MSB >> px_ff[2:0];
            end else if (!line_done) begin
               err_in = err_ff - (step_x ? $signed({4'b0, dy_ff}) : 12'sd0)
                               + (step_y ? $signed({4'b0, dx_ff}) : 12'sd0);
               if (step_x) begin
                  px_in = sx_ff ? px_ff + 8'd1 : px_ff - 8'd1;
               end
               if (step_y) begin
                  py_in = sy_ff ? py_ff + 8'd1 : py_ff - 8'd1;
               end
            end
         end
         mfsr_pkg::B_READW: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = ram_rdata;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mfsr_pkg::B_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff       <= px_in;
      py_ff       <= py_in;
      ex_ff       <= ex_in;
      ey_ff       <= ey_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      err_ff      <= err_in;
      widx_ff     <= widx_in;
      mask_ff     <= mask_in;
      rsp_data_ff <= rsp_data_in;
   end

   // No result is offered while the framebuffer is being cleared.
   assert property (@(posedge clock) disable iff (reset) clearing |-> !rsp_valid_ff)
      else $error("result offered during clearing pass");

   // The framebuffer is written only by the clearing pass or a pixel write.
   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == mfsr_pkg::B_WRITE || state_ff == mfsr_pkg::B_CLEAR))
      else $error("unexpected framebuffer write");

   // A pixel write always follows the read of the same byte.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == mfsr_pkg::B_WRITE) |-> ($past(state_ff) == mfsr_pkg::B_PIX))
      else $error("pixel write without a preceding read");

   // Each read result is captured into the result register in the read-wait state.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == mfsr_pkg::B_READW) |=> rsp_valid_ff)
      else $error("read result not captured");

endmodule

FILE: hw/rtl/mono_framebuffer_shape_rasterizer.sv
// Top level of the monochrome framebuffer shape rasterizer.
// Depends on mfsr_pkg, mfsr_front, mfsr_fifo and mfsr_back.
//
//   Channel   Ports                          Moves
//   command   req_push / req_full, req_*     one command word per shape or read
//   result    rsp_pop / rsp_empty, rsp_*     one result word per command
//
// A command is set up in the front end; a drawn pixel that lands on the screen takes a
// read state and a write state, one that falls off it only the read state, set by the
// single framebuffer port doing a read-modify-write per pixel; a read command passes
// the idle and read-wait states. After reset the framebuffer is cleared one byte a cycle,
// ROW_BYTES * SCREEN_HEIGHT bytes (1024 at the default size), and req_full stays high
// meanwhile. The front end takes a new command once it has queued every job of the last
// one. A result waits in an output register; while it is not popped, reads and command
// ends stall the back end, and the job queue lets the front end run ahead.

module mono_framebuffer_shape_rasterizer #(
   parameter int SCREEN_WIDTH  = mfsr_pkg::DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = mfsr_pkg::DEF_SCREEN_HEIGHT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [3:0] req_cmd,
   input  logic [7:0] req_ax,
   input  logic [7:0] req_ay,
   input  logic [7:0] req_bx,
   input  logic [7:0] req_by,
   input  logic [7:0] req_cx,
   input  logic [7:0] req_cy,
   input  logic [7:0] req_extent_w,
   input  logic [7:0] req_extent_h,
   input  logic [7:0] req_radius,
   input  logic [9:0] req_read_addr,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_read_data
);

   logic              front_busy, clearing, accept;
   logic              job_push, job_full, job_pop, job_empty;
   logic              rsp_valid;
   mfsr_pkg::job_type push_job, pop_job;

   // Commands are held off while the front end is busy or the screen is clearing.
   assign req_full  = front_busy || clearing;
   assign accept    = req_push && !req_full;
   assign rsp_empty = !rsp_valid;

   mfsr_front #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .cmd       (req_cmd),
      .ax        (req_ax),
      .ay        (req_ay),
      .bx        (req_bx),
      .by        (req_by),
      .cx        (req_cx),
      .cy        (req_cy),
      .extent_w  (req_extent_w),
      .extent_h  (req_extent_h),
      .radius    (req_radius),
      .read_addr (req_read_addr),
      .busy      (front_busy),
      .job_push  (job_push),
      .job       (push_job),
      .job_full  (job_full)
   );

   mfsr_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push && !job_full),
      .push_data (push_job),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (pop_job),
      .empty     (job_empty)
   );

   mfsr_back #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (pop_job),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_read_data),
      .rsp_take  (rsp_pop)
   );

endmodule
